// ===== hdl/bpc_pkg.sv =====
// Package for the button press classifier: press class codes, state and flag
// structs, and register reset values. No dependencies.
package bpc_pkg;

    // Press class codes; code 3 is never produced and is handled like LONG.
    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_PRESS = 2'd1,
        CLASS_LONG  = 2'd2
    } t_class;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 8'd1;

    // Register reset values
    localparam logic [15:0] MIN_PRESS_RST  = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd600;

    // Classifier state carried from poll to poll
    typedef struct packed {
        logic        last_pressed;
        logic        held;
        logic [31:0] press_start;
        t_class      press_class;
    } t_state;

    // Per-poll result flags
    typedef struct packed {
        logic toggled;
        logic went_down;
        logic went_up;
        logic short_press;
        logic long_press;
        logic long_held;
        logic is_down;
    } t_flags;

endpackage

// ===== hdl/bpc_eval.sv =====
// Next-state and flag logic for one button poll.
// Depends on bpc_pkg.
module bpc_eval
    import bpc_pkg::*;
(
    input  t_state      i_state,
    input  logic        i_pin_level,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_min_press_ms,
    input  logic [15:0] i_long_press_ms,
    output t_state      o_state,
    output t_flags      o_flags
);

    logic        pressed;
    logic [31:0] elapsed;

    // Pin is active low; elapsed time wraps modulo 2^32
    assign pressed = ~i_pin_level;
    assign elapsed = i_now_ms - i_state.press_start;

    always_comb begin
        o_state              = i_state;
        o_flags              = '0;
        o_state.last_pressed = pressed;

        if (pressed != i_state.last_pressed) begin
            // Level change: start or end a press
            o_flags.toggled = 1'b1;
            if (pressed) begin
                o_state.press_start = i_now_ms;
                o_state.held        = 1'b1;
                o_flags.went_down   = 1'b1;
            end else begin
                o_flags.short_press = (i_state.press_class == CLASS_PRESS);
                o_flags.went_up     = 1'b1;
                o_state.press_class = CLASS_NONE;
                o_state.held        = 1'b0;
                o_state.press_start = '0;
            end
        end else if (i_state.held) begin
            // Held: test the long threshold first, then the minimum
            if (elapsed > {16'd0, i_long_press_ms}) begin
                if (i_state.press_class == CLASS_NONE ||
                    i_state.press_class == CLASS_PRESS) begin
                    o_flags.long_press  = 1'b1;
                    o_state.press_class = CLASS_LONG;
                end else begin
                    o_flags.long_held = 1'b1;
                end
            end else if (elapsed > {16'd0, i_min_press_ms}) begin
                o_state.press_class = CLASS_PRESS;
            end
        end

        o_flags.is_down = o_state.held;
    end

endmodule

// ===== hdl/button_press_classifier_core.sv =====
// A result is registered and valid in the cycle after its poll transaction is
// accepted. Throughput: one poll per cycle while o_stall is low; the classify
// logic is combinational between the state registers and the result register.
// Reset (synchronous, active low): state and result valid clear, the
// thresholds return to 50 ms and 600 ms.
// Top level of the button press classifier. Depends on bpc_pkg and bpc_eval.
module button_press_classifier_core
    import bpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // poll input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_pin_level,
    input  logic [31:0]          i_now_ms,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_toggled,
    output logic                 o_went_down,
    output logic                 o_went_up,
    output logic                 o_short_press,
    output logic                 o_long_press,
    output logic                 o_long_held,
    output logic                 o_is_down,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic        r_valid;
    t_flags      r_flags;
    t_state      r_state;
    t_state      n_state;
    t_flags      n_flags;
    logic [15:0] r_min_press_ms;
    logic [15:0] r_long_press_ms;
    logic        in_accept;

    // Accept a poll whenever the result register is free or draining
    assign o_stall     = r_valid & i_stall;
    assign in_accept   = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    bpc_eval u_eval (
        .i_state         (r_state),
        .i_pin_level     (i_pin_level),
        .i_now_ms        (i_now_ms),
        .i_min_press_ms  (r_min_press_ms),
        .i_long_press_ms (r_long_press_ms),
        .o_state         (n_state),
        .o_flags         (n_flags)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_press_ms  <= MIN_PRESS_RST;
            r_long_press_ms <= LONG_PRESS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_PRESS:  r_min_press_ms  <= i_cfg_data;
                CFG_LONG_PRESS: r_long_press_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance state on each accepted poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{last_pressed: 1'b0, held: 1'b0, press_start: '0,
                         press_class: CLASS_NONE};
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result register valid: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_accept) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_flags <= n_flags;
        end
    end

    assign o_valid       = r_valid;
    assign o_toggled     = r_flags.toggled;
    assign o_went_down   = r_flags.went_down;
    assign o_went_up     = r_flags.went_up;
    assign o_short_press = r_flags.short_press;
    assign o_long_press  = r_flags.long_press;
    assign o_long_held   = r_flags.long_held;
    assign o_is_down     = r_flags.is_down;

endmodule

// ===== hdl/bpc_checker.sv =====
// Port-level checks for button_press_classifier_core, bound to the top level.
// Depends only on the top level's port names.
module bpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_pin_level,
    input logic [31:0] i_now_ms,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_toggled,
    input logic        o_went_down,
    input logic        o_went_up,
    input logic        o_short_press,
    input logic        o_long_press,
    input logic        o_long_held,
    input logic        o_is_down
);

    // Hold a stalled poll transaction
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable({i_pin_level, i_now_ms}))
        else $error("stalled poll changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid &&
            $stable({o_toggled, o_went_down, o_went_up, o_short_press,
                     o_long_press, o_long_held, o_is_down}))
        else $error("stalled result changed");

    // Edges toggle and set the held level consistently
    a_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_went_down || o_went_up) |->
            o_toggled && (o_went_down != o_went_up) && (o_is_down == o_went_down))
        else $error("edge flags inconsistent");

    // A short press is reported only on release
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_short_press |-> o_went_up)
        else $error("short press without release");

    // Long flags only while held and without a level change
    a_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_long_press || o_long_held) |->
            o_is_down && !o_toggled && !(o_long_press && o_long_held))
        else $error("long flags inconsistent");

endmodule

bind button_press_classifier_core bpc_checker u_bpc_checker (.*);
